FILE: sv/cle_pkg.sv
// shared constants, types and key codes of the console line editor
`timescale 1ns / 1ps

package cle_pkg;

    // line store default size and byte/word geometry
    localparam int LINE_LEN_DEF = 256;
    localparam int BYTE_W       = 8;
    localparam int WORD_BYTES   = 8;
    localparam int WORD_W       = BYTE_W * WORD_BYTES;
    localparam int CNT_W        = 4;
    localparam int TDATA_OUT_W  = 72;

    // editing keys in cooked mode
    localparam logic [BYTE_W-1:0] KEY_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] KEY_EOF  = 8'h04;
    localparam logic [BYTE_W-1:0] KEY_BS   = 8'h08;
    localparam logic [BYTE_W-1:0] KEY_NL   = 8'h0A;
    localparam logic [BYTE_W-1:0] KEY_KILL = 8'h15;

    // flush sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PACK = 3'b010,
        S_SEND = 3'b100
    } t_state;

    // controls for the shared byte shift unit
    typedef struct packed {
        logic clear;
        logic shift;
        logic use_data;
    } t_pack_ctl;

endpackage

FILE: sv/cle_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cle_shift_unit.sv
// shared byte shift unit that assembles one output word a byte per cycle
`timescale 1ns / 1ps

module cle_shift_unit
    import cle_pkg::*;
(
    input  logic              i_clk,
    input  t_pack_ctl         i_ctl,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [BYTE_W-1:0] shift_in;

    // bytes enter at the top and walk down, so the first byte ends in the low bits
    always_comb begin
        shift_in = i_ctl.use_data ? i_byte : '0;
        n_word   = r_word;
        if (i_ctl.clear) begin
            n_word = '0;
        end else if (i_ctl.shift) begin
            n_word = {shift_in, r_word[WORD_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: sv/console_line_editor_top.sv
// top level of the console line editor: editing, line store and flush sequencer
`timescale 1ns / 1ps

// Console input line editor.
// Input stream: i_s_tdata carries one keyboard byte, i_s_tuser says that more
// bytes are queued behind it. Configuration: i_cfg_wr_en/i_cfg_wr_data write
// raw_mode (1 = unedited bytes, 0 = cooked editing) at any clock edge.
// Output stream: each request carries up to eight line bytes packed first byte
// lowest, their count, and tlast on the final word of a line. An empty line
// (end of input) gives one word with count 0.
// Flow: a byte that does not end or fill the line is taken and the block
// stays ready for the next byte. A byte that ends the line, or fills the line
// store, starts a flush: each word is built in the shift unit from eight byte
// shifts fed by the one read port of the line store, and then waits in the
// output register until it is taken. The input is not ready during a flush.
// An empty line goes straight to the output register as one word.
// Reset (synchronous, active low) empties the line, clears raw_mode and drops
// any flush in progress; the line store contents are not cleared.
// A stalled receiver holds the current word and tlast steady in the output
// register; the flush resumes once the word is taken.

module console_line_editor_top
    import cle_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [BYTE_W-1:0]      i_s_tdata,   // [7:0] ch
    input  logic                   i_s_tuser,   // [0] more_pending
    // output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,   // [63:0] line_word, [67:64] byte_count
    output logic                   o_m_tlast    // last_of_line
);

    localparam int AW = $clog2(LINE_LEN);
    localparam int FW = $clog2(LINE_LEN + 1);

    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0]  r_wlen, n_wlen;
    logic [CNT_W-1:0]  r_bcnt, n_bcnt;
    logic              r_last, n_last;
    logic              r_raw;

    logic              in_acc;
    logic              put;
    logic              send;
    logic [FW-1:0]     edit_fill;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;
    t_pack_ctl         pack_ctl;
    logic [WORD_W-1:0] word;

    // bytes left in the line, capped at one word
    function automatic logic [CNT_W-1:0] word_len(input logic [FW-1:0] left);
        if (left > FW'(WORD_BYTES)) begin
            return CNT_W'(WORD_BYTES);
        end
        return left[CNT_W-1:0];
    endfunction

    assign in_acc = i_s_tvalid && o_s_tready;

    // line editing decision for the byte at the input
    always_comb begin
        put       = 1'b0;
        send      = 1'b0;
        edit_fill = r_fill;
        if (i_s_tdata == KEY_NUL) begin
            send = (r_fill != '0) && !i_s_tuser;
        end else if (r_raw) begin
            put  = 1'b1;
            send = !i_s_tuser;
        end else begin
            unique case (i_s_tdata)
                KEY_BS: begin
                    if (r_fill != '0) begin
                        edit_fill = r_fill - FW'(1);
                    end
                end
                KEY_KILL: begin
                    edit_fill = '0;
                end
                KEY_NL: begin
                    put  = 1'b1;
                    send = 1'b1;
                end
                KEY_EOF: begin
                    send = 1'b1;
                end
                default: begin
                    put = 1'b1;
                end
            endcase
        end
        if (put) begin
            edit_fill = r_fill + FW'(1);
        end
    end

    // flush sequencer
    always_comb begin
        n_state           = r_state;
        n_fill            = r_fill;
        n_ptr             = r_ptr;
        n_step            = r_step;
        n_wlen            = r_wlen;
        n_bcnt            = r_bcnt;
        n_last            = r_last;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        pack_ctl          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    ram_we = put;
                    n_fill = edit_fill;
                    if (send || edit_fill == FW'(LINE_LEN)) begin
                        if (edit_fill == '0) begin
                            n_state        = S_SEND;
                            pack_ctl.clear = 1'b1;
                            n_bcnt         = '0;
                            n_last         = 1'b1;
                        end else begin
                            n_state = S_PACK;
                            n_ptr   = '0;
                            n_step  = '0;
                            n_wlen  = word_len(edit_fill);
                        end
                    end
                end
            end
            S_PACK: begin
                // read ahead one byte, shift in the byte read in the cycle before
                if (r_step < CNT_W'(WORD_BYTES) && r_step < r_wlen) begin
                    ram_re = 1'b1;
                    n_ptr  = r_ptr + FW'(1);
                end
                if (r_step != '0) begin
                    pack_ctl.shift    = 1'b1;
                    pack_ctl.use_data = (r_step - CNT_W'(1)) < r_wlen;
                end
                n_step = r_step + CNT_W'(1);
                if (r_step == CNT_W'(WORD_BYTES)) begin
                    n_state = S_SEND;
                    n_bcnt  = r_wlen;
                    n_last  = (r_ptr == r_fill);
                end
            end
            S_SEND: begin
                if (i_m_tready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                        n_fill  = '0;
                    end else begin
                        n_state = S_PACK;
                        n_step  = '0;
                        n_wlen  = word_len(r_fill - r_ptr);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_raw   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_wr_en) begin
                r_raw <= i_cfg_wr_data;
            end
        end
    end

    // word bookkeeping
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_step <= n_step;
        r_wlen <= n_wlen;
        r_bcnt <= n_bcnt;
        r_last <= n_last;
    end

    cle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_LEN)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    cle_shift_unit u_shift (
        .i_clk  (i_clk),
        .i_ctl  (pack_ctl),
        .i_byte (ram_rdata),
        .o_word (word)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_SEND);
    assign o_m_tdata  = {{(TDATA_OUT_W - WORD_W - CNT_W){1'b0}}, r_bcnt, word};
    assign o_m_tlast  = r_last;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_LEN))
        else $error("fill index beyond line length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_bcnt <= CNT_W'(WORD_BYTES))
        else $error("word byte count above eight");

    a_full_inner_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> r_bcnt == CNT_W'(WORD_BYTES))
        else $error("inner word of a line not full");

    a_ptr_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PACK) |-> r_ptr <= r_fill)
        else $error("read pointer past end of line");

endmodule
